// File: hdl/mtc_pkg.sv
package mtc_pkg;

	localparam int unsigned PIX_W   = 8;
	localparam int unsigned CFG_W   = 13;
	localparam int unsigned COORD_W = 12;
	localparam int unsigned COUNT_W = 25;
	localparam int unsigned SUM_W   = 36;
	localparam int unsigned IDX_W   = 3;

	localparam logic [COUNT_W-1:0] COUNT_LIMIT = 25'd16777216;

	localparam logic [IDX_W-1:0] REG_THRESHOLD     = 3'd0;
	localparam logic [IDX_W-1:0] REG_MASK_DIAMETER = 3'd1;
	localparam logic [IDX_W-1:0] REG_OFFSET_X      = 3'd2;
	localparam logic [IDX_W-1:0] REG_OFFSET_Y      = 3'd3;
	localparam logic [IDX_W-1:0] REG_FRAME_WIDTH   = 3'd4;
	localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT  = 3'd5;

	localparam int unsigned FIFO_DEPTH = 2;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned DIV_STEPS  = COORD_W;

	typedef struct packed {
		logic [PIX_W-1:0]        threshold;
		logic [CFG_W-1:0]        mask_diameter;
		logic signed [CFG_W-1:0] offset_x;
		logic signed [CFG_W-1:0] offset_y;
		logic [CFG_W-1:0]        frame_width;
		logic [CFG_W-1:0]        frame_height;
	} cfg_t;

	typedef struct packed {
		logic [COUNT_W-1:0] count;
		logic [SUM_W-1:0]   sum_x;
		logic [SUM_W-1:0]   sum_y;
	} frame_sum_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_status_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_HOLD
	} back_state_t;

endpackage

// File: hdl/mtc_front.sv
module mtc_front import mtc_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cfg_t             cfg,
	input  logic             in_valid,
	input  logic [PIX_W-1:0] pixel,
	input  logic             frame_end,
	output logic             stall,
	input  fifo_status_t     fifo_status,
	output logic             fifo_push,
	output frame_sum_t       fifo_data
);

	localparam logic [CFG_W-1:0] WIDTH_CAP =
		CFG_W'((MAX_WIDTH < 4096) ? MAX_WIDTH : 4096);

	logic [COORD_W-1:0] col_q, row_q;
	logic [CFG_W-1:0]   row_len;
	logic [CFG_W-1:0]   col_next;
	logic               accept, adv;

	logic signed [CFG_W:0]   cx, cy;
	logic signed [CFG_W+1:0] dx, dy;
	logic [COORD_W-1:0]      radius;
	logic [2*COORD_W-1:0]    r_sq;
	logic [2*COORD_W-1:0]    r_sq_q;

	logic                    v_s1, v_s2, v_s3;
	logic                    gt_s1, gt_s2, gt_s3;
	logic                    last_s1, last_s2, last_s3;
	logic [COORD_W-1:0]      col_s1, col_s2, col_s3;
	logic [COORD_W-1:0]      row_s1, row_s2, row_s3;
	logic signed [CFG_W+1:0] dx_s1, dy_s1;
	logic signed [2*CFG_W+3:0] dx_prod, dy_prod;
	logic [26:0]             dx2_s2, dy2_s2;
	logic [27:0]             dist_sq;
	logic                    inside_s3;

	logic               qual;
	logic [COUNT_W-1:0] cnt_q, cnt_new;
	logic [SUM_W-1:0]   sx_q, sy_q, sx_new, sy_new;

	assign stall  = v_s3 & last_s3 & fifo_status.full;
	assign adv    = ~stall;
	assign accept = in_valid & ~stall;

	// position counters
	always_comb begin
		if (cfg.frame_width == '0) begin
			row_len = CFG_W'(1);
		end else if (cfg.frame_width > WIDTH_CAP) begin
			row_len = WIDTH_CAP;
		end else begin
			row_len = cfg.frame_width;
		end
	end

	assign col_next = {1'b0, col_q} + CFG_W'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (frame_end) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_next >= row_len) begin
				col_q <= '0;
				row_q <= row_q + COORD_W'(1);
			end else begin
				col_q <= col_next[COORD_W-1:0];
			end
		end
	end

	// mask geometry
	assign cx = $signed({2'b00, cfg.frame_width[CFG_W-1:1]})
		+ $signed({cfg.offset_x[CFG_W-1], cfg.offset_x});
	assign cy = $signed({2'b00, cfg.frame_height[CFG_W-1:1]})
		+ $signed({cfg.offset_y[CFG_W-1], cfg.offset_y});
	assign dx = $signed({3'b000, col_q}) - $signed({cx[CFG_W], cx});
	assign dy = $signed({3'b000, row_q}) - $signed({cy[CFG_W], cy});

	assign radius = cfg.mask_diameter[CFG_W-1:1];
	assign r_sq   = {{COORD_W{1'b0}}, radius} * {{COORD_W{1'b0}}, radius};

	always_ff @(posedge clk) begin
		r_sq_q <= r_sq;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	assign dx_prod = dx_s1 * dx_s1;
	assign dy_prod = dy_s1 * dy_s1;
	assign dist_sq = {1'b0, dx2_s2} + {1'b0, dy2_s2};

	always_ff @(posedge clk) begin
		if (adv) begin
			gt_s1   <= pixel > cfg.threshold;
			last_s1 <= frame_end;
			col_s1  <= col_q;
			row_s1  <= row_q;
			dx_s1   <= dx;
			dy_s1   <= dy;

			gt_s2   <= gt_s1;
			last_s2 <= last_s1;
			col_s2  <= col_s1;
			row_s2  <= row_s1;
			dx2_s2  <= dx_prod[26:0];
			dy2_s2  <= dy_prod[26:0];

			gt_s3     <= gt_s2;
			last_s3   <= last_s2;
			col_s3    <= col_s2;
			row_s3    <= row_s2;
			inside_s3 <= (dist_sq <= {4'b0000, r_sq_q});
		end
	end

	// accumulators
	assign qual = gt_s3 & inside_s3 & (cnt_q < COUNT_LIMIT);

	always_comb begin
		if (qual) begin
			cnt_new = cnt_q + COUNT_W'(1);
			sx_new  = sx_q + SUM_W'(col_s3);
			sy_new  = sy_q + SUM_W'(row_s3);
		end else begin
			cnt_new = cnt_q;
			sx_new  = sx_q;
			sy_new  = sy_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			sx_q  <= '0;
			sy_q  <= '0;
		end else if (v_s3 && adv) begin
			if (last_s3) begin
				cnt_q <= '0;
				sx_q  <= '0;
				sy_q  <= '0;
			end else begin
				cnt_q <= cnt_new;
				sx_q  <= sx_new;
				sy_q  <= sy_new;
			end
		end
	end

	assign fifo_push       = v_s3 & last_s3 & adv;
	assign fifo_data.count = cnt_new;
	assign fifo_data.sum_x = sx_new;
	assign fifo_data.sum_y = sy_new;

endmodule

// File: hdl/mtc_fifo.sv
module mtc_fifo import mtc_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  frame_sum_t   wr_data,
	input  logic         pop,
	output frame_sum_t   rd_data,
	output fifo_status_t status
);

	frame_sum_t              mem_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [FIFO_PTR_W:0]     fill_q;
	logic                    do_push, do_pop;

	assign status.empty = (fill_q == '0);
	assign status.full  = (fill_q == (FIFO_PTR_W+1)'(FIFO_DEPTH));
	assign do_push      = push & ~status.full;
	assign do_pop       = pop & ~status.empty;
	assign rd_data      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == FIFO_PTR_W'(FIFO_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// File: hdl/mtc_back.sv
module mtc_back import mtc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  fifo_status_t       fifo_status,
	input  frame_sum_t         fifo_data,
	output logic               fifo_pop,
	output logic               empty,
	input  logic               pop,
	output logic [COORD_W-1:0] center_x,
	output logic [COORD_W-1:0] center_y,
	output logic               dark,
	output logic [COUNT_W-1:0] pixel_count
);

	localparam int unsigned STEP_W = $clog2(DIV_STEPS);

	back_state_t state_q, state_d;

	logic [COUNT_W-1:0] cnt_q;
	logic [COUNT_W-1:0] remx_q, remy_q;
	logic [COORD_W-1:0] shx_q, shy_q;
	logic [STEP_W-1:0]  step_q;
	logic [COORD_W-1:0] held_x_q, held_y_q;
	logic               out_valid_q;

	logic               slot_free, out_load, div_last;
	logic [COUNT_W:0]   candx, candy;
	logic               bitx, bity;

	assign slot_free = ~out_valid_q | pop;
	assign div_last  = (step_q == STEP_W'(DIV_STEPS-1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!fifo_status.empty) begin
					state_d = (fifo_data.count == '0) ? BK_HOLD : BK_DIV;
				end
			end
			BK_DIV: begin
				if (div_last) begin
					state_d = BK_HOLD;
				end
			end
			BK_HOLD: begin
				if (slot_free) begin
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_IDLE;
		endcase
	end

	always_comb begin
		fifo_pop = 1'b0;
		out_load = 1'b0;
		case (state_q)
			BK_IDLE: fifo_pop = ~fifo_status.empty;
			BK_HOLD: out_load = slot_free;
			default: begin
				fifo_pop = 1'b0;
				out_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BK_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// restoring divide, one quotient bit per cycle for both axes
	assign candx = {remx_q, shx_q[COORD_W-1]};
	assign candy = {remy_q, shy_q[COORD_W-1]};
	assign bitx  = candx >= {1'b0, cnt_q};
	assign bity  = candy >= {1'b0, cnt_q};

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			cnt_q  <= fifo_data.count;
			remx_q <= {1'b0, fifo_data.sum_x[SUM_W-1:COORD_W]};
			remy_q <= {1'b0, fifo_data.sum_y[SUM_W-1:COORD_W]};
			shx_q  <= fifo_data.sum_x[COORD_W-1:0];
			shy_q  <= fifo_data.sum_y[COORD_W-1:0];
			step_q <= '0;
		end else if (state_q == BK_DIV) begin
			remx_q <= bitx ? COUNT_W'(candx - {1'b0, cnt_q}) : candx[COUNT_W-1:0];
			remy_q <= bity ? COUNT_W'(candy - {1'b0, cnt_q}) : candy[COUNT_W-1:0];
			shx_q  <= {shx_q[COORD_W-2:0], bitx};
			shy_q  <= {shy_q[COORD_W-2:0], bity};
			step_q <= step_q + 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_x_q    <= '0;
			held_y_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
				if (cnt_q != '0) begin
					held_x_q <= shx_q;
					held_y_q <= shy_q;
				end
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			pixel_count <= cnt_q;
			if (cnt_q == '0) begin
				center_x <= held_x_q;
				center_y <= held_y_q;
				dark     <= 1'b1;
			end else begin
				center_x <= shx_q;
				center_y <= shy_q;
				dark     <= 1'b0;
			end
		end
	end

	assign empty = ~out_valid_q;

endmodule

// File: hdl/masked_threshold_centroid_top.sv
// Centroid of the bright pixels of a frame inside a circular mask. Pixels go in
// raster order, one per clock while full is low, with frame_end on the last
// pixel of each frame; the column and row come from internal counters that
// follow frame_width. Each pixel passes a three-stage mask pipeline (offsets,
// squares, radius compare) and then the running sums. At the end of a frame its
// totals go into a two-entry queue and a shared restoring divider works out
// both coordinates. full only rises when two frame totals are queued and a
// third frame ends, which needs frames shorter than the divide time or a result
// side that holds off pop. Write configuration with no frame in flight and the
// result queue drained.
module masked_threshold_centroid_top import mtc_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [PIX_W-1:0]   pixel,
	input  logic               frame_end,
	output logic               empty,
	input  logic               pop,
	output logic [COORD_W-1:0] center_x,
	output logic [COORD_W-1:0] center_y,
	output logic               dark,
	output logic [COUNT_W-1:0] pixel_count,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [IDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]   cfg_data
);

	cfg_t         cfg_q;
	fifo_status_t fifo_status;
	frame_sum_t   push_data, pop_data;
	logic         fifo_push, fifo_pop;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold     <= 8'd48;
			cfg_q.mask_diameter <= 13'd480;
			cfg_q.offset_x      <= '0;
			cfg_q.offset_y      <= '0;
			cfg_q.frame_width   <= 13'd640;
			cfg_q.frame_height  <= 13'd480;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_THRESHOLD:     cfg_q.threshold     <= cfg_data[PIX_W-1:0];
				REG_MASK_DIAMETER: cfg_q.mask_diameter <= cfg_data;
				REG_OFFSET_X:      cfg_q.offset_x      <= cfg_data;
				REG_OFFSET_Y:      cfg_q.offset_y      <= cfg_data;
				REG_FRAME_WIDTH:   cfg_q.frame_width   <= cfg_data;
				REG_FRAME_HEIGHT:  cfg_q.frame_height  <= cfg_data;
				default: cfg_q <= cfg_q;
			endcase
		end
	end

	mtc_front #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.in_valid    (push),
		.pixel       (pixel),
		.frame_end   (frame_end),
		.stall       (full),
		.fifo_status (fifo_status),
		.fifo_push   (fifo_push),
		.fifo_data   (push_data)
	);

	mtc_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (fifo_push),
		.wr_data (push_data),
		.pop     (fifo_pop),
		.rd_data (pop_data),
		.status  (fifo_status)
	);

	mtc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.fifo_status (fifo_status),
		.fifo_data   (pop_data),
		.fifo_pop    (fifo_pop),
		.empty       (empty),
		.pop         (pop),
		.center_x    (center_x),
		.center_y    (center_y),
		.dark        (dark),
		.pixel_count (pixel_count)
	);

endmodule
